// ----- sv/sdbl_pkg.sv -----
package sdbl_pkg;

    localparam int unsigned NUM_DIRS = 8;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CENTER,
        ST_SCAN,
        ST_LAST,
        ST_DONE
    } state_t;

    // neighbor offsets in priority order, later wins on equal drop
    function automatic logic signed [1:0] step_row(input logic [2:0] d);
        case (d)
            3'd0: step_row = 2'sd0;
            3'd1: step_row = 2'sd0;
            3'd2: step_row = -2'sd1;
            3'd3: step_row = -2'sd1;
            3'd4: step_row = 2'sd1;
            3'd5: step_row = 2'sd1;
            3'd6: step_row = -2'sd1;
            default: step_row = 2'sd1;
        endcase
    endfunction

    function automatic logic signed [1:0] step_col(input logic [2:0] d);
        case (d)
            3'd0: step_col = -2'sd1;
            3'd1: step_col = 2'sd1;
            3'd2: step_col = -2'sd1;
            3'd3: step_col = 2'sd1;
            3'd4: step_col = -2'sd1;
            3'd5: step_col = 2'sd1;
            default: step_col = 2'sd0;
        endcase
    endfunction

endpackage

// ----- sv/steepest_descent_basin_label_unit.sv -----
// load transaction: no result; input stalls until each result is taken
// query: per visited pixel a center read, 8 neighbor reads, a compare and a hop,
// and the result is valid when the walk stops, after at most 255 hops
// an out-of-range query has its result valid the cycle after accept
// aresetn (synchronous, active low) clears control and walk position and sets the size
// registers to 256; the image memory is not cleared and unwritten pixels read undefined
module steepest_descent_basin_label_unit #(
    parameter int unsigned MAX_ROWS = 256,
    parameter int unsigned MAX_COLS = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // row[7:0], col[15:8], grey_value[23:16]
    input  logic        s_tuser,   // mode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // basin_row[7:0], basin_col[15:8]
    output logic        m_tuser,   // out_of_range
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [8:0]  cfg_data
);

    localparam int unsigned DEPTH = MAX_ROWS * MAX_COLS;
    localparam int unsigned AW = $clog2(DEPTH);
    localparam int unsigned RW = $clog2(MAX_ROWS + 1);
    localparam int unsigned CW = $clog2(MAX_COLS + 1);

    logic [8:0] rows_cfg_reg, cols_cfg_reg;
    logic [RW-1:0] rows_eff;
    logic [CW-1:0] cols_eff;

    always_comb begin
        if (rows_cfg_reg == 9'd0) rows_eff = RW'(1);
        else if (32'(rows_cfg_reg) > MAX_ROWS) rows_eff = RW'(MAX_ROWS);
        else rows_eff = RW'(rows_cfg_reg);
        if (cols_cfg_reg == 9'd0) cols_eff = CW'(1);
        else if (32'(cols_cfg_reg) > MAX_COLS) cols_eff = CW'(MAX_COLS);
        else cols_eff = CW'(cols_cfg_reg);
    end

    logic [AW-1:0] col_stride;
    assign col_stride = AW'(cols_eff);
    logic [7:0] in_row, in_col, in_grey;
    assign in_row  = s_tdata[7:0];
    assign in_col  = s_tdata[15:8];
    assign in_grey = s_tdata[23:16];

    sdbl_pkg::state_t state_reg, state_next;
    logic [7:0] walk_row_reg, walk_row_next, walk_col_reg, walk_col_next;
    logic [2:0] dir_reg, dir_next;
    logic [7:0] cur_reg, cur_next, best_reg, best_next;
    logic [2:0] bdir_reg, bdir_next;
    logic       found_reg, found_next;
    logic       pend_reg, pend_next;    // a neighbor read is in flight
    logic [2:0] pdir_reg, pdir_next;
    logic       m_valid_reg, m_valid_next, oor_reg, oor_next;

    logic [7:0] mem [DEPTH];
    logic [7:0] rd_data;
    logic [AW-1:0] rd_addr, wr_addr;
    logic       wr_en;

    // neighbor under consideration
    logic signed [9:0] nr, nc;
    logic n_inside;
    assign nr = $signed({2'b0, walk_row_reg}) + 10'(sdbl_pkg::step_row(dir_reg));
    assign nc = $signed({2'b0, walk_col_reg}) + 10'(sdbl_pkg::step_col(dir_reg));
    assign n_inside = (nr >= 0) && (nc >= 0) && (32'(nr) < 32'(rows_eff))
                      && (32'(nc) < 32'(cols_eff));

    logic in_inside;
    assign in_inside = (32'(in_row) < 32'(rows_eff)) && (32'(in_col) < 32'(cols_eff));

    // drop of the neighbor read last cycle
    logic [8:0] drop;
    assign drop = {1'b0, cur_reg} - {1'b0, rd_data};

    assign s_tready = (state_reg == sdbl_pkg::ST_IDLE) && !m_valid_reg;

    always_comb begin
        state_next = state_reg;
        walk_row_next = walk_row_reg;
        walk_col_next = walk_col_reg;
        dir_next = dir_reg;
        cur_next = cur_reg;
        best_next = best_reg;
        bdir_next = bdir_reg;
        found_next = found_reg;
        pend_next = 1'b0;
        pdir_next = dir_reg;
        m_valid_next = m_valid_reg && !m_tready;
        oor_next = oor_reg;
        rd_addr = AW'(walk_row_reg) * col_stride + AW'(walk_col_reg);
        wr_addr = AW'(in_row) * col_stride + AW'(in_col);
        wr_en = 1'b0;
        // neighbor result from previous cycle
        if (pend_reg && !drop[8] && drop != 9'd0 && drop[7:0] >= best_reg) begin
            best_next = drop[7:0];
            bdir_next = pdir_reg;
            found_next = 1'b1;
        end
        case (state_reg)
            sdbl_pkg::ST_IDLE: begin
                if (s_tvalid && s_tready) begin
                    if (!s_tuser) begin
                        wr_en = in_inside;
                    end else if (!in_inside) begin
                        m_valid_next = 1'b1;
                        oor_next = 1'b1;
                    end else begin
                        walk_row_next = in_row;
                        walk_col_next = in_col;
                        state_next = sdbl_pkg::ST_CENTER;
                    end
                end
            end
            sdbl_pkg::ST_CENTER: begin
                // center read issued this cycle
                dir_next = 3'd0;
                best_next = 8'd0;
                found_next = 1'b0;
                state_next = sdbl_pkg::ST_SCAN;
            end
            sdbl_pkg::ST_SCAN: begin
                if (dir_reg == 3'd0) cur_next = rd_data;
                rd_addr = AW'(nr[7:0]) * col_stride + AW'(nc[7:0]);
                pend_next = n_inside;
                dir_next = dir_reg + 3'd1;
                if (dir_reg == 3'(sdbl_pkg::NUM_DIRS - 1)) state_next = sdbl_pkg::ST_LAST;
            end
            sdbl_pkg::ST_LAST: begin
                // best choice settles after the last neighbor compare
                state_next = sdbl_pkg::ST_DONE;
            end
            sdbl_pkg::ST_DONE: begin
                if (found_reg) begin
                    walk_row_next = walk_row_reg + 8'(sdbl_pkg::step_row(bdir_reg));
                    walk_col_next = walk_col_reg + 8'(sdbl_pkg::step_col(bdir_reg));
                    state_next = sdbl_pkg::ST_CENTER;
                end else begin
                    m_valid_next = 1'b1;
                    oor_next = 1'b0;
                    state_next = sdbl_pkg::ST_IDLE;
                end
            end
            default: state_next = sdbl_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (wr_en) mem[wr_addr] <= in_grey;
        rd_data <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= sdbl_pkg::ST_IDLE;
            rows_cfg_reg <= 9'd256;
            cols_cfg_reg <= 9'd256;
            walk_row_reg <= 8'd0;
            walk_col_reg <= 8'd0;
            m_valid_reg <= 1'b0;
            pend_reg <= 1'b0;
            found_reg <= 1'b0;
        end else begin
            if (cfg_we && !cfg_index) rows_cfg_reg <= cfg_data;
            if (cfg_we && cfg_index) cols_cfg_reg <= cfg_data;
            state_reg <= state_next;
            walk_row_reg <= walk_row_next;
            walk_col_reg <= walk_col_next;
            m_valid_reg <= m_valid_next;
            pend_reg <= pend_next;
            found_reg <= found_next;
        end
        dir_reg <= dir_next;
        cur_reg <= cur_next;
        best_reg <= best_next;
        bdir_reg <= bdir_next;
        pdir_reg <= pdir_next;
        oor_reg <= oor_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = oor_reg;
    assign m_tdata  = oor_reg ? 16'd0 : {walk_col_reg, walk_row_reg};

`ifndef NO_ASSERTIONS
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != sdbl_pkg::ST_IDLE) |-> !s_tready)
        else $error("input accepted during walk");
    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("result changed while stalled");
    a_found_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == sdbl_pkg::ST_DONE && found_reg) |-> (best_reg != 8'd0))
        else $error("hop taken without a drop");
    a_scan_after_center: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == sdbl_pkg::ST_CENTER) |=> (state_reg == sdbl_pkg::ST_SCAN
        && dir_reg == 3'd0))
        else $error("scan did not start at first direction");
`endif

endmodule
